>>> sv/cdd_pkg.sv
// Shared constants, tag type and stencil tables for the central difference derivative.
package cdd_pkg;

    localparam int COUNT_BITS  = 4;
    localparam int COUNT_MAX   = 15;
    localparam int WEIGHT_BITS = 11;
    localparam int DEN_BITS    = 10;
    localparam int DIV_STEPS   = 4;
    localparam int RESULT_BITS = 32;
    localparam int STEP_BITS   = 24;
    localparam int STEP_SPLIT  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_BITS    = 24;

    localparam logic [0:0] REG_STENCIL_ORDER = 1'b0;
    localparam logic [0:0] REG_INVERSE_STEP  = 1'b1;

    // travels alongside each beat through the arithmetic pipeline
    typedef struct packed {
        logic       valid;
        logic       has_result;
        logic       zero_out;
        logic       negative;
        logic [1:0] sel;
        logic [2:0] flush;
    } cdd_tag_t;

    function automatic logic signed [WEIGHT_BITS-1:0] stencil_weight(
        input logic [1:0] sel,
        input int unsigned tap
    );
        logic signed [WEIGHT_BITS-1:0] w;
        w = '0;
        case (sel)
            2'd0:
            begin
                if (tap == 0) w = 11'sd1;
            end
            2'd1:
            begin
                if (tap == 0) w = 11'sd8;
                else if (tap == 1) w = -11'sd1;
            end
            2'd2:
            begin
                if (tap == 0) w = 11'sd45;
                else if (tap == 1) w = -11'sd9;
                else if (tap == 2) w = 11'sd1;
            end
            default:
            begin
                if (tap == 0) w = 11'sd672;
                else if (tap == 1) w = -11'sd168;
                else if (tap == 2) w = 11'sd32;
                else if (tap == 3) w = -11'sd3;
            end
        endcase
        return w;
    endfunction

    function automatic logic [DEN_BITS-1:0] stencil_denom(input logic [1:0] sel);
        logic [DEN_BITS-1:0] d;
        unique case (sel)
            2'd0: d = 10'd2;
            2'd1: d = 10'd12;
            2'd2: d = 10'd60;
            2'd3: d = 10'd840;
            default: d = 10'd2;
        endcase
        return d;
    endfunction

endpackage

>>> sv/cdd_in_if.sv
// Sample channel: valid/ready handshake carrying one input sample per beat.
interface cdd_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          record_end;

    modport source (output valid, output sample_value, output record_end, input ready);
    modport sink   (input valid, input sample_value, input record_end, output ready);
endinterface

>>> sv/cdd_out_if.sv
// Result channel: valid/ready handshake carrying one derivative result per beat.
interface cdd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] derivative_value;
    logic               edge_zero;
    logic               saturated;
    logic               last_of_record;

    modport source (output valid, output derivative_value, output edge_zero,
                    output saturated, output last_of_record, input ready);
    modport sink   (input valid, input derivative_value, input edge_zero,
                    input saturated, input last_of_record, output ready);
endinterface

>>> sv/central_difference_derivative.sv
// Top level: delay line of tap cells, stencil sum, scaling multiply, divider cells, emitter.
// Throughput: one sample beat per cycle unless the output stalls; a record_end beat
// releasing k extra edge zeros holds input until they leave; the output moves one a cycle.
// Path: s1 differences, s2 sum, s3 and s4 scaling multiply, s5 rounding, then NS divider
// cells of 4 quotient bits each (9 cells at default sizes), then emitter pending and output.
// Reset (async, active low) clears delay line, count, valids and output valid; 3-point, step 1.0.
module central_difference_derivative import cdd_pkg::*; #(
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_HALF_WIDTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    cdd_in_if.sink              samples,
    cdd_out_if.source           results
);

    localparam int DEPTH     = 2 * MAX_HALF_WIDTH + 1;
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int SW        = SAMPLE_BITS + 11;
    localparam int ACC_BITS  = SW + 3;
    localparam int PP_BITS   = SW + STEP_SPLIT + 1;
    localparam int PW        = SW + STEP_BITS + 1;
    localparam int DIVD_BITS = PW - FRAC_BITS;
    localparam int QW_MIN    = (DIVD_BITS > 36) ? DIVD_BITS : 36;
    localparam int NS        = (QW_MIN + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QW        = NS * DIV_STEPS;

    logic [1:0]           order_reg;
    logic [STEP_BITS-1:0] inv_step_reg;
    logic [COUNT_BITS-1:0] seen_reg;
    logic [COUNT_BITS-1:0] seen_next;

    logic advance;
    logic accept;

    logic signed [SAMPLE_BITS-1:0] hist [0:DEPTH-1];
    logic signed [SAMPLE_BITS-1:0] nh   [0:DEPTH-1];

    logic [2:0] order_p1;
    logic [2:0] half_w;
    logic [1:0] sel;
    logic [COUNT_BITS:0] have;
    cdd_tag_t tag_front;
    logic signed [DIFF_BITS-1:0] diff [1:MAX_HALF_WIDTH];

    cdd_tag_t                    s1_tag_reg;
    logic signed [DIFF_BITS-1:0] s1_diff_reg [1:MAX_HALF_WIDTH];
    cdd_tag_t                    s2_tag_reg;
    logic signed [SW-1:0]        s2_sum_reg;
    logic signed [ACC_BITS-1:0]  acc;
    cdd_tag_t                    s3_tag_reg;
    logic signed [PP_BITS-1:0]   s3_lo_reg;
    logic signed [PP_BITS-1:0]   s3_hi_reg;
    cdd_tag_t                    s4_tag_reg;
    logic signed [PW-1:0]        s4_prod_reg;
    cdd_tag_t                    s5_tag_reg;
    cdd_tag_t                    s5_tag_next;
    logic [PW-1:0]               s5_mag_reg;
    logic [PW-1:0]               s5_mag_next;

    logic [DEN_BITS-1:0] rem_chain  [0:NS];
    logic [QW-1:0]       work_chain [0:NS];
    cdd_tag_t            tag_chain  [0:NS];

    assign accept        = samples.valid && advance;
    assign samples.ready = advance;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg    <= 2'd0;
            inv_step_reg <= 24'd65536;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STENCIL_ORDER: order_reg    <= cfg_data[1:0];
                REG_INVERSE_STEP:  inv_step_reg <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // delay line
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_tap
            if (gi == 0)
            begin : g_head
                cdd_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (accept),
                    .upstream (samples.sample_value),
                    .tap      (hist[gi])
                );
            end
            else
            begin : g_body
                cdd_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (accept),
                    .upstream (hist[gi-1]),
                    .tap      (hist[gi])
                );
            end
        end
    endgenerate

    // history as it stands once this beat has shifted in
    always_comb
    begin
        nh[0] = samples.sample_value;
        for (int i = 1; i < DEPTH; i++)
        begin
            nh[i] = hist[i-1];
        end
    end

    // stencil selection and record bookkeeping
    always_comb
    begin
        order_p1 = {1'b0, order_reg} + 3'd1;
        half_w   = (order_p1 > 3'(MAX_HALF_WIDTH)) ? 3'(MAX_HALF_WIDTH) : order_p1;
        sel      = 2'(half_w - 3'd1);
        have     = {1'b0, seen_reg} + 5'd1;

        tag_front            = '0;
        tag_front.valid      = accept;
        tag_front.has_result = (seen_reg >= {1'b0, half_w});
        tag_front.zero_out   = (seen_reg < {half_w, 1'b0});
        tag_front.sel        = sel;
        if (samples.record_end)
        begin
            tag_front.flush = (have < {2'b00, half_w}) ? have[2:0] : half_w;
            seen_next       = '0;
        end
        else
        begin
            tag_front.flush = 3'd0;
            seen_next       = (seen_reg < 4'(COUNT_MAX)) ? seen_reg + 4'd1 : seen_reg;
        end

        for (int j = 1; j <= MAX_HALF_WIDTH; j++)
        begin
            diff[j] = '0;
            for (int hh = 1; hh <= MAX_HALF_WIDTH; hh++)
            begin
                if ((half_w == 3'(hh)) && (j <= hh))
                begin
                    diff[j] = DIFF_BITS'(nh[(hh >= j) ? (hh - j) : 0])
                            - DIFF_BITS'(nh[hh + j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
        end
    end

    // weighted sum of symmetric differences
    always_comb
    begin
        acc = '0;
        for (int j = 1; j <= MAX_HALF_WIDTH; j++)
        begin
            acc = acc + ACC_BITS'(s1_diff_reg[j])
                      * ACC_BITS'(stencil_weight(s1_tag_reg.sel, j - 1));
        end
    end

    // scaling: sign-magnitude with the rounding half folded into the same add
    always_comb
    begin
        logic [PW-1:0] base;
        logic [PW-1:0] half;
        s5_tag_next          = s4_tag_reg;
        s5_tag_next.negative = s4_prod_reg[PW-1];
        base                 = s4_prod_reg[PW-1] ? ~s4_prod_reg : s4_prod_reg;
        half                 = PW'({stencil_denom(s4_tag_reg.sel), 15'd0});
        s5_mag_next          = base + half + PW'(s4_prod_reg[PW-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
        end
        else if (advance)
        begin
            s1_tag_reg <= tag_front;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s5_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 1; j <= MAX_HALF_WIDTH; j++)
            begin
                s1_diff_reg[j] <= diff[j];
            end
            s2_sum_reg  <= acc[SW-1:0];
            s3_lo_reg   <= PP_BITS'(s2_sum_reg)
                         * PP_BITS'($signed({1'b0, inv_step_reg[STEP_SPLIT-1:0]}));
            s3_hi_reg   <= PP_BITS'(s2_sum_reg)
                         * PP_BITS'($signed({1'b0, inv_step_reg[STEP_BITS-1:STEP_SPLIT]}));
            s4_prod_reg <= PW'(s3_lo_reg) + (PW'(s3_hi_reg) <<< STEP_SPLIT);
            s5_mag_reg  <= s5_mag_next;
        end
    end

    // divide by the stencil denominator after dropping the fraction bits
    assign rem_chain[0]  = '0;
    assign work_chain[0] = QW'(s5_mag_reg[PW-1:FRAC_BITS]);
    assign tag_chain[0]  = s5_tag_reg;

    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_div
            cdd_div_cell #(.QW(QW)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .rem_in   (rem_chain[gi]),
                .work_in  (work_chain[gi]),
                .tag_in   (tag_chain[gi]),
                .rem_out  (rem_chain[gi+1]),
                .work_out (work_chain[gi+1]),
                .tag_out  (tag_chain[gi+1])
            );
        end
    endgenerate

    cdd_emitter #(.QW(QW)) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .quotient (work_chain[NS]),
        .tag      (tag_chain[NS]),
        .advance  (advance),
        .results  (results)
    );

endmodule

>>> sv/cdd_tap_cell.sv
// One tap of the sample delay line; loads its upstream neighbor on each accepted beat.
module cdd_tap_cell import cdd_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic signed [SAMPLE_BITS-1:0] upstream,
    output logic signed [SAMPLE_BITS-1:0] tap
);

    logic signed [SAMPLE_BITS-1:0] tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (shift)
        begin
            tap_reg <= upstream;
        end
    end

    assign tap = tap_reg;

endmodule

>>> sv/cdd_div_cell.sv
// One cell of the pipelined restoring divider: retires DIV_STEPS quotient bits.
module cdd_div_cell import cdd_pkg::*; #(
    parameter int QW = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [DEN_BITS-1:0] rem_in,
    input  logic [QW-1:0]       work_in,
    input  cdd_tag_t            tag_in,
    output logic [DEN_BITS-1:0] rem_out,
    output logic [QW-1:0]       work_out,
    output cdd_tag_t            tag_out
);

    logic [DEN_BITS-1:0] rem_next;
    logic [QW-1:0]       work_next;
    logic [DEN_BITS-1:0] rem_reg;
    logic [QW-1:0]       work_reg;
    cdd_tag_t            tag_reg;

    // work shifts dividend bits out of the top and quotient bits in at the bottom
    always_comb
    begin
        logic [DEN_BITS:0]   trial;
        logic [DEN_BITS-1:0] den;
        den       = stencil_denom(tag_in.sel);
        rem_next  = rem_in;
        work_next = work_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial     = {rem_next, work_next[QW-1]};
            work_next = {work_next[QW-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                trial        = trial - {1'b0, den};
                work_next[0] = 1'b1;
            end
            rem_next = trial[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rem_out  = rem_reg;
    assign work_out = work_reg;
    assign tag_out  = tag_reg;

endmodule

>>> sv/cdd_emitter.sv
// Result sequencer: saturates the quotient, then emits the regular result and
// any trailing edge zeros one beat at a time through an output register.
module cdd_emitter import cdd_pkg::*; #(
    parameter int QW = 36
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [QW-1:0] quotient,
    input  cdd_tag_t      tag,
    output logic          advance,
    cdd_out_if.source     results
);

    logic                          pend_res_reg;
    logic                          pend_res_next;
    logic [2:0]                    pend_flush_reg;
    logic [2:0]                    pend_flush_next;
    logic signed [RESULT_BITS-1:0] pend_val_reg;
    logic signed [RESULT_BITS-1:0] pend_val_next;
    logic                          pend_zero_reg;
    logic                          pend_zero_next;
    logic                          pend_sat_reg;
    logic                          pend_sat_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [RESULT_BITS-1:0] out_val_reg;
    logic signed [RESULT_BITS-1:0] out_val_next;
    logic                          out_zero_reg;
    logic                          out_zero_next;
    logic                          out_sat_reg;
    logic                          out_sat_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    logic out_free;
    logic emit_res;
    logic emit_flush;
    logic pending_one;
    logic sat_pos;
    logic sat_neg;

    always_comb
    begin
        out_free    = !out_valid_reg || results.ready;
        emit_res    = out_free && pend_res_reg;
        emit_flush  = out_free && !pend_res_reg && (pend_flush_reg != 3'd0);
        pending_one = (({2'b00, pend_res_reg} + pend_flush_reg) == 3'd1);
        advance     = (!pend_res_reg && (pend_flush_reg == 3'd0)) || (out_free && pending_one);
    end

    // magnitude limits: +2^31-1 and -2^31
    assign sat_pos = |quotient[QW-1:31];
    assign sat_neg = (|quotient[QW-1:32]) || (quotient[31] && (|quotient[30:0]));

    always_comb
    begin
        pend_res_next   = pend_res_reg;
        pend_flush_next = pend_flush_reg;
        pend_val_next   = pend_val_reg;
        pend_zero_next  = pend_zero_reg;
        pend_sat_next   = pend_sat_reg;
        if (advance)
        begin
            pend_res_next   = tag.valid && tag.has_result;
            pend_flush_next = tag.valid ? tag.flush : 3'd0;
            pend_zero_next  = tag.zero_out;
            if (tag.zero_out)
            begin
                pend_val_next = '0;
                pend_sat_next = 1'b0;
            end
            else if (tag.negative)
            begin
                pend_sat_next = sat_neg;
                pend_val_next = sat_neg ? 32'sh8000_0000 : -$signed(quotient[31:0]);
            end
            else
            begin
                pend_sat_next = sat_pos;
                pend_val_next = sat_pos ? 32'sh7FFF_FFFF : $signed(quotient[31:0]);
            end
        end
        else if (emit_res)
        begin
            pend_res_next = 1'b0;
        end
        else if (emit_flush)
        begin
            pend_flush_next = pend_flush_reg - 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_zero_next  = out_zero_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = emit_res || emit_flush;
            if (emit_res)
            begin
                out_val_next  = pend_val_reg;
                out_zero_next = pend_zero_reg;
                out_sat_next  = pend_sat_reg;
                out_last_next = 1'b0;
            end
            else
            begin
                out_val_next  = '0;
                out_zero_next = 1'b1;
                out_sat_next  = 1'b0;
                out_last_next = (pend_flush_reg == 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_res_reg   <= 1'b0;
            pend_flush_reg <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_res_reg   <= pend_res_next;
            pend_flush_reg <= pend_flush_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg  <= pend_val_next;
        pend_zero_reg <= pend_zero_next;
        pend_sat_reg  <= pend_sat_next;
        out_val_reg   <= out_val_next;
        out_zero_reg  <= out_zero_next;
        out_sat_reg   <= out_sat_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.derivative_value = out_val_reg;
    assign results.edge_zero        = out_zero_reg;
    assign results.saturated        = out_sat_reg;
    assign results.last_of_record   = out_last_reg;

endmodule
